// ===== hw/rtl/glyph_quad_generator_defines.svh =====
// ----------------------------------------------------------------------------
// glyph quad generator assertion macros
// Clocked assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef GLYPH_QUAD_GENERATOR_DEFINES_SVH
`define GLYPH_QUAD_GENERATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// checked only outside reset
`define GQG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
// checked at every edge, reset included
`define GQG_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define GQG_ASSERT(label, prop, msg)
`define GQG_ASSERT_RST(label, prop, msg)
`endif
`endif

// ===== hw/rtl/gqg_pkg.sv =====
// ----------------------------------------------------------------------------
// gqg_pkg
// Constants, codes and types shared by the glyph quad generator.
// ----------------------------------------------------------------------------
package gqg_pkg;

    localparam int GLYPH_COUNT = 256;
    localparam int COORD_BITS  = 12;
    localparam int IDX_BITS    = $clog2(GLYPH_COUNT);
    localparam int ENTRY_BITS  = 4 * COORD_BITS;

    localparam int CHAR_BITS   = 8;
    localparam int FIELD_BITS  = 12;
    localparam int TEXT_H_BITS = 16;
    localparam int ATLAS_BITS  = 13;
    localparam int FRAC_BITS   = 16;
    localparam int TEX_BITS    = FRAC_BITS + 1;
    localparam int POS_X_BITS  = 32;
    localparam int QCNT_BITS   = 14;
    localparam int CORNER_BITS = 2;
    localparam int VIDX_BITS   = QCNT_BITS + CORNER_BITS;

    // width division: text_height * glyph_w, one quotient bit per cycle
    localparam int PROD_BITS   = TEXT_H_BITS + COORD_BITS;
    localparam int NUM_BITS    = COORD_BITS + 1;
    localparam int TCMP_BITS   = (NUM_BITS > ATLAS_BITS) ? NUM_BITS : ATLAS_BITS;
    localparam int CNT_BITS    = $clog2(PROD_BITS);
    localparam int LANES       = 4;

    localparam logic [TEX_BITS-1:0] TEX_ONE = TEX_BITS'(1 << FRAC_BITS);

    // stream packing
    localparam int S_RAW_BITS   = CHAR_BITS + 4 * FIELD_BITS;
    localparam int S_TDATA_BITS = ((S_RAW_BITS + 7) / 8) * 8;
    localparam int S_TUSER_BITS = 2;
    localparam int TU_OP        = 0;
    localparam int TU_START     = 1;
    localparam int M_RAW_BITS   = CORNER_BITS + POS_X_BITS + TEXT_H_BITS
                                + 2 * TEX_BITS + VIDX_BITS;
    localparam int M_TDATA_BITS = ((M_RAW_BITS + 7) / 8) * 8;

    // configuration registers
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TEXT_HEIGHT  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ATLAS_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ATLAS_HEIGHT = 2'd2;
    localparam logic [TEXT_H_BITS-1:0] TEXT_H_RESET = 16'd256;
    localparam logic [ATLAS_BITS-1:0]  ATLAS_RESET  = 13'd256;

    localparam logic [CORNER_BITS-1:0] CORNER_LAST = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_DIV  = 5'b00100,
        S_FIN  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

endpackage

// ===== hw/rtl/glyph_quad_generator.sv =====
// ----------------------------------------------------------------------------
// glyph_quad_generator
// Looks up glyphs per character code and emits four textured quad corners.
//
//   channel   dir  handshake                     content
//   s_axis    in   s_axis_tvalid / s_axis_tready  load or render item
//   m_axis    out  m_axis_tvalid / m_axis_tready  one quad corner per beat
//   cfg       in   i_cfg_valid / o_cfg_ready      register index and value
//
// A load beat is a single table write. A render beat runs one table read,
// a bit-serial width division over PROD_BITS quotient bits with the four
// texture divisions running alongside, one saturating add, four corner beats.
// Reset is synchronous; the glyph table has no reset and needs no sweep.
// A stalled m_axis holds the corner sequence; s_axis is ready only when idle.
// ----------------------------------------------------------------------------
`include "glyph_quad_generator_defines.svh"

module glyph_quad_generator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // s_axis_tdata: char_code, glyph_w, glyph_h, glyph_x, glyph_y
    input  logic [gqg_pkg::S_TDATA_BITS-1:0]     s_axis_tdata,
    // s_axis_tuser: op, string_start
    input  logic [gqg_pkg::S_TUSER_BITS-1:0]     s_axis_tuser,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // m_axis_tdata: corner, pos_x, pos_y, tex_u, tex_v, vertex_index
    output logic [gqg_pkg::M_TDATA_BITS-1:0]     m_axis_tdata,
    output logic                                 m_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [gqg_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [gqg_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    import gqg_pkg::*;

    // control state
    t_state                 r_state;
    logic [CNT_BITS-1:0]    r_cnt;
    logic [CORNER_BITS-1:0] r_k;
    logic [POS_X_BITS-1:0]  r_xoff;
    logic [QCNT_BITS-1:0]   r_qcnt;
    logic                   r_ovalid;
    logic [TEXT_H_BITS-1:0] r_text_h;
    logic [ATLAS_BITS-1:0]  r_atlas_w;
    logic [ATLAS_BITS-1:0]  r_atlas_h;

    // datapath
    logic [PROD_BITS-1:0]   r_wq;
    logic [COORD_BITS-1:0]  r_wrem;
    logic [COORD_BITS-1:0]  r_wden;
    logic                   r_wzero;
    logic [ATLAS_BITS-1:0]  r_trem [LANES];
    logic [FRAC_BITS-1:0]   r_tq   [LANES];
    logic                   r_tsat [LANES];
    logic [POS_X_BITS-1:0]  r_xright;

    logic [CORNER_BITS-1:0] r_o_corner;
    logic [POS_X_BITS-1:0]  r_o_posx;
    logic [TEXT_H_BITS-1:0] r_o_posy;
    logic [TEX_BITS-1:0]    r_o_texu;
    logic [TEX_BITS-1:0]    r_o_texv;
    logic [VIDX_BITS-1:0]   r_o_vidx;
    logic                   r_o_last;

    t_state                 n_state;

    logic                   w_in_acc;
    logic                   w_render;
    logic                   w_out_load;
    logic [IDX_BITS+CHAR_BITS-1:0]   w_code_ext;
    logic [IDX_BITS-1:0]             w_idx;
    logic [COORD_BITS+FIELD_BITS-1:0] w_fw, w_fh, w_fx, w_fy;
    logic [ENTRY_BITS-1:0]  w_wentry;
    logic [ENTRY_BITS-1:0]  w_rentry;
    logic [COORD_BITS-1:0]  w_gw, w_gh, w_gx, w_gy;
    logic [NUM_BITS-1:0]    w_tnum [LANES];
    logic [ATLAS_BITS-1:0]  w_tden [LANES];
    logic [COORD_BITS:0]    w_wsh;
    logic [COORD_BITS+1:0]  w_wdiff;
    logic                   w_wge;
    logic [ATLAS_BITS:0]    w_tsh   [LANES];
    logic [ATLAS_BITS+1:0]  w_tdiff [LANES];
    logic                   w_tge   [LANES];
    logic [TEX_BITS-1:0]    w_tex   [LANES];
    logic [PROD_BITS-1:0]   w_width;
    logic [POS_X_BITS:0]    w_sum;
    logic                   w_right;
    logic                   w_last_step;

    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_render = s_axis_tuser[TU_OP];

    // table index and stored coordinate fields
    assign w_code_ext = {{IDX_BITS{1'b0}}, s_axis_tdata[CHAR_BITS-1:0]};
    assign w_idx      = w_code_ext[IDX_BITS-1:0];
    assign w_fw = {{COORD_BITS{1'b0}}, s_axis_tdata[CHAR_BITS+FIELD_BITS-1 -: FIELD_BITS]};
    assign w_fh = {{COORD_BITS{1'b0}}, s_axis_tdata[CHAR_BITS+2*FIELD_BITS-1 -: FIELD_BITS]};
    assign w_fx = {{COORD_BITS{1'b0}}, s_axis_tdata[CHAR_BITS+3*FIELD_BITS-1 -: FIELD_BITS]};
    assign w_fy = {{COORD_BITS{1'b0}}, s_axis_tdata[CHAR_BITS+4*FIELD_BITS-1 -: FIELD_BITS]};
    assign w_wentry = {w_fy[COORD_BITS-1:0], w_fx[COORD_BITS-1:0],
                       w_fh[COORD_BITS-1:0], w_fw[COORD_BITS-1:0]};

    gqg_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (GLYPH_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && !w_render),
        .i_waddr (w_idx),
        .i_wdata (w_wentry),
        .i_raddr (w_idx),
        .o_rdata (w_rentry)
    );

    assign w_gw = w_rentry[COORD_BITS-1:0];
    assign w_gh = w_rentry[2*COORD_BITS-1 -: COORD_BITS];
    assign w_gx = w_rentry[3*COORD_BITS-1 -: COORD_BITS];
    assign w_gy = w_rentry[4*COORD_BITS-1 -: COORD_BITS];

    // lanes: u left, u right, v bottom, v top
    assign w_tnum[0] = NUM_BITS'(w_gx);
    assign w_tnum[1] = NUM_BITS'(w_gx) + NUM_BITS'(w_gw);
    assign w_tnum[2] = NUM_BITS'(w_gy) + NUM_BITS'(w_gh);
    assign w_tnum[3] = NUM_BITS'(w_gy);
    assign w_tden[0] = r_atlas_w;
    assign w_tden[1] = r_atlas_w;
    assign w_tden[2] = r_atlas_h;
    assign w_tden[3] = r_atlas_h;

    // one restoring step of the width division
    assign w_wsh   = {r_wrem, r_wq[PROD_BITS-1]};
    assign w_wdiff = {1'b0, w_wsh} - {2'b00, r_wden};
    assign w_wge   = !w_wdiff[COORD_BITS+1];

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            w_tsh[i]   = {r_trem[i], 1'b0};
            w_tdiff[i] = {1'b0, w_tsh[i]} - {2'b00, w_tden[i]};
            w_tge[i]   = !w_tdiff[i][ATLAS_BITS+1];
            w_tex[i]   = r_tsat[i] ? TEX_ONE : TEX_BITS'(r_tq[i]);
        end
    end

    assign w_width     = r_wzero ? '0 : r_wq;
    assign w_sum       = (POS_X_BITS+1)'(r_xoff) + (POS_X_BITS+1)'(w_width);
    assign w_last_step = (r_cnt == CNT_BITS'(PROD_BITS - 1));
    assign w_right     = (r_k == 2'd1) || (r_k == 2'd2);
    assign w_out_load  = (r_state == S_EMIT) && (!r_ovalid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && w_render) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_DIV;
            S_DIV: begin
                if (w_last_step) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: n_state = S_EMIT;
            S_EMIT: begin
                if (w_out_load && (r_k == CORNER_LAST)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_k       <= '0;
            r_xoff    <= '0;
            r_qcnt    <= '0;
            r_ovalid  <= 1'b0;
            r_text_h  <= TEXT_H_RESET;
            r_atlas_w <= ATLAS_RESET;
            r_atlas_h <= ATLAS_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_TEXT_HEIGHT:  r_text_h  <= i_cfg_data;
                    CFG_ATLAS_WIDTH:  r_atlas_w <= i_cfg_data[ATLAS_BITS-1:0];
                    CFG_ATLAS_HEIGHT: r_atlas_h <= i_cfg_data[ATLAS_BITS-1:0];
                    default: ;
                endcase
            end
            if (w_in_acc && w_render && s_axis_tuser[TU_START]) begin
                r_xoff <= '0;
                r_qcnt <= '0;
            end
            if (r_state == S_READ) begin
                r_cnt <= '0;
            end else if (r_state == S_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_out_load) begin
                r_ovalid <= 1'b1;
                r_k      <= r_k + 1'b1;
                if (r_k == CORNER_LAST) begin
                    r_xoff <= r_xright;
                    r_qcnt <= r_qcnt + 1'b1;
                end
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_wq    <= PROD_BITS'(r_text_h) * PROD_BITS'(w_gw);
            r_wrem  <= '0;
            r_wden  <= w_gh;
            r_wzero <= (w_gh == '0);
            for (int i = 0; i < LANES; i++) begin
                // a numerator at or above the atlas size saturates at 1.0
                r_tsat[i] <= TCMP_BITS'(w_tnum[i]) >= TCMP_BITS'(w_tden[i]);
                r_trem[i] <= ATLAS_BITS'(w_tnum[i]);
                r_tq[i]   <= '0;
            end
        end else if (r_state == S_DIV) begin
            r_wrem <= w_wge ? w_wdiff[COORD_BITS-1:0] : w_wsh[COORD_BITS-1:0];
            r_wq   <= {r_wq[PROD_BITS-2:0], w_wge};
            if (r_cnt < CNT_BITS'(FRAC_BITS)) begin
                for (int i = 0; i < LANES; i++) begin
                    r_trem[i] <= w_tge[i] ? w_tdiff[i][ATLAS_BITS-1:0]
                                          : w_tsh[i][ATLAS_BITS-1:0];
                    r_tq[i]   <= {r_tq[i][FRAC_BITS-2:0], w_tge[i]};
                end
            end
        end
        if (r_state == S_FIN) begin
            r_xright <= w_sum[POS_X_BITS] ? '1 : w_sum[POS_X_BITS-1:0];
        end
        if (w_out_load) begin
            r_o_corner <= r_k;
            r_o_posx   <= w_right ? r_xright : r_xoff;
            r_o_posy   <= r_k[1] ? r_text_h : '0;
            r_o_texu   <= w_right ? w_tex[1] : w_tex[0];
            r_o_texv   <= r_k[1] ? w_tex[3] : w_tex[2];
            r_o_vidx   <= {r_qcnt, r_k};
            r_o_last   <= (r_k == CORNER_LAST);
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = M_TDATA_BITS'({r_o_vidx, r_o_texv, r_o_texu,
                                          r_o_posy, r_o_posx, r_o_corner});

    `GQG_ASSERT(a_render_reads,
        (s_axis_tvalid && s_axis_tready && s_axis_tuser[TU_OP]) |=> (r_state == S_READ),
        "render beat did not start a table read")
    `GQG_ASSERT(a_vidx_corner,
        m_axis_tvalid |-> (r_o_vidx[CORNER_BITS-1:0] == r_o_corner),
        "vertex index does not match corner")
    `GQG_ASSERT(a_tex_range,
        m_axis_tvalid |-> ((r_o_texu <= TEX_ONE) && (r_o_texv <= TEX_ONE)),
        "texture coordinate above 1.0")
    `GQG_ASSERT_RST(a_reset_clears,
        !i_rst_n |=> (!m_axis_tvalid && (r_state == S_IDLE)),
        "control state not cleared by reset")

endmodule

// ===== hw/rtl/gqg_ram.sv =====
// ----------------------------------------------------------------------------
// gqg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gqg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/gqg_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gqg_tb_pkg
// Item codes and input beat layout shared by the quad generator testbench.
// ----------------------------------------------------------------------------
package gqg_tb_pkg;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_RENDER = 1'b1
    } t_glyph_op;

    // s_axis_tdata layout, lowest bits first
    localparam int S_CODE_LSB = 0;
    localparam int S_W_LSB    = S_CODE_LSB + gqg_pkg::CHAR_BITS;
    localparam int S_H_LSB    = S_W_LSB + gqg_pkg::FIELD_BITS;
    localparam int S_X_LSB    = S_H_LSB + gqg_pkg::FIELD_BITS;
    localparam int S_Y_LSB    = S_X_LSB + gqg_pkg::FIELD_BITS;

endpackage

// ===== tb/tb_glyph_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_glyph_checker
// Watches the item, corner and register channels of the quad generator,
// keeps its own glyph table, pen position and quad count, predicts the four
// corner beats of every rendered character and compares them in order.
// ----------------------------------------------------------------------------
module tb_glyph_checker
    import gqg_pkg::*;
    import gqg_tb_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [S_TDATA_BITS-1:0]     i_s_tdata,
    input  logic [S_TUSER_BITS-1:0]     i_s_tuser,
    input  logic                        i_s_tvalid,
    input  logic                        i_s_tready,
    input  logic [M_TDATA_BITS-1:0]     i_m_tdata,
    input  logic                        i_m_tlast,
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]    i_cfg_data,
    output logic [31:0]                 o_fail_count,
    output logic [31:0]                 o_pending
);

    localparam int M_POSX_LSB  = CORNER_BITS;
    localparam int M_POSY_LSB  = M_POSX_LSB + POS_X_BITS;
    localparam int M_U_LSB     = M_POSY_LSB + TEXT_H_BITS;
    localparam int M_V_LSB     = M_U_LSB + TEX_BITS;
    localparam int M_VIDX_LSB  = M_V_LSB + TEX_BITS;

    typedef struct packed {
        logic [CORNER_BITS-1:0] corner;
        logic [POS_X_BITS-1:0]  pos_x;
        logic [TEXT_H_BITS-1:0] pos_y;
        logic [TEX_BITS-1:0]    tex_u;
        logic [TEX_BITS-1:0]    tex_v;
        logic [VIDX_BITS-1:0]   vidx;
        logic                   last;
    } t_corner_beat;

    logic [COORD_BITS-1:0]  glyph_w_tab [GLYPH_COUNT];
    logic [COORD_BITS-1:0]  glyph_h_tab [GLYPH_COUNT];
    logic [COORD_BITS-1:0]  glyph_x_tab [GLYPH_COUNT];
    logic [COORD_BITS-1:0]  glyph_y_tab [GLYPH_COUNT];
    logic [POS_X_BITS-1:0]  pen_x;
    logic [QCNT_BITS-1:0]   quads_drawn;
    logic [TEXT_H_BITS-1:0] text_h;
    logic [ATLAS_BITS-1:0]  atlas_w;
    logic [ATLAS_BITS-1:0]  atlas_h;
    t_corner_beat           corners_due [$];
    int unsigned            mismatches = 0;

    // truncating Q1.16 ratio, clamped at 1.0; a zero divisor reads as 1.0
    function automatic logic [TEX_BITS-1:0] tex_fraction(
        input logic [NUM_BITS-1:0]   num,
        input logic [ATLAS_BITS-1:0] den
    );
        logic [47:0] quot;
        if (den == '0) begin
            return TEX_ONE;
        end
        quot = (48'(num) << FRAC_BITS) / 48'(den);
        if (quot > 48'(TEX_ONE)) begin
            return TEX_ONE;
        end
        return quot[TEX_BITS-1:0];
    endfunction

    task automatic predict_quad(input logic [IDX_BITS-1:0] code, input logic start);
        logic [63:0]            prod;
        logic [POS_X_BITS-1:0]  width;
        logic [POS_X_BITS:0]    sum;
        logic [POS_X_BITS-1:0]  right_x;
        logic [TEX_BITS-1:0]    u_left, u_right, v_bottom, v_top;
        logic                   is_right, is_top;
        t_corner_beat           beat;
        int                     k;
        if (start) begin
            pen_x       = '0;
            quads_drawn = '0;
        end
        prod  = 64'(text_h) * 64'(glyph_w_tab[code]);
        width = (glyph_h_tab[code] == '0) ? '0
              : POS_X_BITS'(prod / 64'(glyph_h_tab[code]));
        sum     = {1'b0, pen_x} + {1'b0, width};
        right_x = sum[POS_X_BITS] ? '1 : sum[POS_X_BITS-1:0];
        u_left   = tex_fraction(NUM_BITS'(glyph_x_tab[code]), atlas_w);
        u_right  = tex_fraction(NUM_BITS'(glyph_x_tab[code]) + NUM_BITS'(glyph_w_tab[code]),
                                atlas_w);
        v_bottom = tex_fraction(NUM_BITS'(glyph_y_tab[code]) + NUM_BITS'(glyph_h_tab[code]),
                                atlas_h);
        v_top    = tex_fraction(NUM_BITS'(glyph_y_tab[code]), atlas_h);
        for (k = 0; k < 4; k++) begin
            is_right    = (k == 1) || (k == 2);
            is_top      = (k >= 2);
            beat.corner = CORNER_BITS'(k);
            beat.pos_x  = is_right ? right_x : pen_x;
            beat.pos_y  = is_top ? text_h : '0;
            beat.tex_u  = is_right ? u_right : u_left;
            beat.tex_v  = is_top ? v_top : v_bottom;
            beat.vidx   = {quads_drawn, 2'b00} + VIDX_BITS'(k);
            beat.last   = (CORNER_BITS'(k) == CORNER_LAST);
            corners_due = {corners_due, beat};
        end
        quads_drawn = quads_drawn + 1'b1;
        pen_x       = right_x;
    endtask

    task automatic take_item(
        input logic [S_TDATA_BITS-1:0] data,
        input logic [S_TUSER_BITS-1:0] user
    );
        logic [IDX_BITS-1:0] code;
        code = data[S_CODE_LSB +: IDX_BITS];
        if (t_glyph_op'(user[TU_OP]) == OP_LOAD) begin
            glyph_w_tab[code] = data[S_W_LSB +: COORD_BITS];
            glyph_h_tab[code] = data[S_H_LSB +: COORD_BITS];
            glyph_x_tab[code] = data[S_X_LSB +: COORD_BITS];
            glyph_y_tab[code] = data[S_Y_LSB +: COORD_BITS];
        end else begin
            predict_quad(code, user[TU_START]);
        end
    endtask

    task automatic write_setting(
        input logic [CFG_INDEX_BITS-1:0] index,
        input logic [CFG_DATA_BITS-1:0]  value
    );
        case (index)
            CFG_TEXT_HEIGHT:  text_h  = value[TEXT_H_BITS-1:0];
            CFG_ATLAS_WIDTH:  atlas_w = value[ATLAS_BITS-1:0];
            CFG_ATLAS_HEIGHT: atlas_h = value[ATLAS_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic check_field(
        input string       name,
        input logic [63:0] want,
        input logic [63:0] got,
        inout logic        bad
    );
        if (got !== want) begin
            $display("%0t: corner %s expected 0x%0h got 0x%0h", $time, name, want, got);
            bad = 1'b1;
        end
    endtask

    task automatic check_corner();
        t_corner_beat want, got;
        logic         bad;
        got.corner = i_m_tdata[0 +: CORNER_BITS];
        got.pos_x  = i_m_tdata[M_POSX_LSB +: POS_X_BITS];
        got.pos_y  = i_m_tdata[M_POSY_LSB +: TEXT_H_BITS];
        got.tex_u  = i_m_tdata[M_U_LSB +: TEX_BITS];
        got.tex_v  = i_m_tdata[M_V_LSB +: TEX_BITS];
        got.vidx   = i_m_tdata[M_VIDX_LSB +: VIDX_BITS];
        got.last   = i_m_tlast;
        if (corners_due.size() == 0) begin
            $display("%0t: corner beat expected none got tdata 0x%0h tlast %0b",
                     $time, i_m_tdata, i_m_tlast);
            mismatches++;
            return;
        end
        want = corners_due.pop_front();
        bad  = 1'b0;
        check_field("corner", 64'(want.corner), 64'(got.corner), bad);
        check_field("pos_x", 64'(want.pos_x), 64'(got.pos_x), bad);
        check_field("pos_y", 64'(want.pos_y), 64'(got.pos_y), bad);
        check_field("tex_u", 64'(want.tex_u), 64'(got.tex_u), bad);
        check_field("tex_v", 64'(want.tex_v), 64'(got.tex_v), bad);
        check_field("vertex_index", 64'(want.vidx), 64'(got.vidx), bad);
        check_field("tlast", 64'(want.last), 64'(got.last), bad);
        if (bad) begin
            mismatches++;
        end
    endtask

    // beats leaving the block are checked before the item taken at the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pen_x       = '0;
            quads_drawn = '0;
            text_h      = TEXT_H_RESET;
            atlas_w     = ATLAS_RESET;
            atlas_h     = ATLAS_RESET;
            corners_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_corner();
            end
            if (i_cfg_valid && i_cfg_ready) begin
                write_setting(i_cfg_index, i_cfg_data);
            end
            if (i_s_tvalid && i_s_tready) begin
                take_item(i_s_tdata, i_s_tuser);
            end
        end
        o_pending    <= corners_due.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives glyph loads, character strings and register settings into the quad
// generator with random gaps and back-pressure; the checker predicts and
// compares every corner beat. Ends with an unbroken string with no gaps on
// either side.
// ----------------------------------------------------------------------------
module tb_top;
    import gqg_pkg::*;
    import gqg_tb_pkg::*;

    localparam int          DRAIN_CYCLES  = 48;
    localparam int          RANDOM_ITEMS  = 32;
    localparam int          TAIL_QUADS    = 24;
    localparam int unsigned LIMIT_CYCLES  = 200_000;

    logic                        i_clk          = 1'b0;
    logic                        i_rst_n        = 1'b0;
    logic [S_TDATA_BITS-1:0]     s_axis_tdata   = '0;
    logic [S_TUSER_BITS-1:0]     s_axis_tuser   = '0;
    logic                        s_axis_tvalid  = 1'b0;
    logic                        s_axis_tready;
    logic [M_TDATA_BITS-1:0]     m_axis_tdata;
    logic                        m_axis_tlast;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready  = 1'b1;
    logic                        i_cfg_valid    = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0]   i_cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0]    i_cfg_data     = '0;

    logic [31:0]                 fail_count;
    logic [31:0]                 pending;
    logic                        quiet          = 1'b0;
    logic                        rx_choppy      = 1'b1;
    logic [2:0]                  rx_hold        = '0;
    int unsigned                 cycle_count    = 0;
    logic                        tx_choppy      = 1'b1;
    logic                        loaded [GLYPH_COUNT];
    logic [IDX_BITS-1:0]         loaded_codes [$];

    glyph_quad_generator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    tb_glyph_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tlast    (m_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        // back-pressure switches between choppy and calm stretches
        if (cycle_count[8:0] == '0) begin
            rx_choppy <= ($urandom_range(0, 2) != 0);
        end
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (quiet) begin
            m_axis_tready <= 1'b1;
            rx_hold       <= '0;
        end else if (rx_hold != '0) begin
            m_axis_tready <= 1'b0;
            rx_hold       <= rx_hold - 1'b1;
        end else if (rx_choppy && $urandom_range(0, 4) == 0) begin
            m_axis_tready <= 1'b0;
            rx_hold       <= 3'($urandom_range(0, 3));
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [FIELD_BITS-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return FIELD_BITS'(1);
            3:       return FIELD_BITS'($urandom_range(0, 15));
            default: return FIELD_BITS'($urandom);
        endcase
    endfunction

    // valid stays high into the next item unless a gap is drawn
    task automatic put_item(
        input t_glyph_op             op,
        input logic [IDX_BITS-1:0]   code,
        input logic                  start,
        input logic [FIELD_BITS-1:0] gw,
        input logic [FIELD_BITS-1:0] gh,
        input logic [FIELD_BITS-1:0] gx,
        input logic [FIELD_BITS-1:0] gy
    );
        logic [S_TDATA_BITS-1:0] word;
        logic [S_TUSER_BITS-1:0] flags;
        word  = '0;
        flags = '0;
        word[S_CODE_LSB +: CHAR_BITS] = code;
        word[S_W_LSB +: FIELD_BITS]   = gw;
        word[S_H_LSB +: FIELD_BITS]   = gh;
        word[S_X_LSB +: FIELD_BITS]   = gx;
        word[S_Y_LSB +: FIELD_BITS]   = gy;
        flags[TU_OP]    = op;
        flags[TU_START] = start;
        s_axis_tdata  <= word;
        s_axis_tuser  <= flags;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (!quiet && tx_choppy && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic load_glyph(
        input logic [IDX_BITS-1:0]   code,
        input logic [FIELD_BITS-1:0] gw,
        input logic [FIELD_BITS-1:0] gh,
        input logic [FIELD_BITS-1:0] gx,
        input logic [FIELD_BITS-1:0] gy,
        input logic                  start
    );
        put_item(OP_LOAD, code, start, gw, gh, gx, gy);
        if (!loaded[code]) begin
            loaded[code] = 1'b1;
            loaded_codes = {loaded_codes, code};
        end
    endtask

    task automatic render_char(input logic [IDX_BITS-1:0] code, input logic start);
        put_item(OP_RENDER, code, start, FIELD_BITS'($urandom), FIELD_BITS'($urandom),
                 FIELD_BITS'($urandom), FIELD_BITS'($urandom));
    endtask

    // hold the sender until every corner is back and the block has gone idle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(
        input logic [TEXT_H_BITS-1:0] th,
        input logic [ATLAS_BITS-1:0]  aw,
        input logic [ATLAS_BITS-1:0]  ah
    );
        int n;
        for (n = 0; n < 3; n++) begin
            i_cfg_valid <= 1'b1;
            case (n)
                0: begin
                    i_cfg_index <= CFG_TEXT_HEIGHT;
                    i_cfg_data  <= CFG_DATA_BITS'(th);
                end
                1: begin
                    i_cfg_index <= CFG_ATLAS_WIDTH;
                    i_cfg_data  <= CFG_DATA_BITS'(aw);
                end
                default: begin
                    i_cfg_index <= CFG_ATLAS_HEIGHT;
                    i_cfg_data  <= CFG_DATA_BITS'(ah);
                end
            endcase
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // mostly strings opening with a start flag, with stray loads and broken starts
    task automatic run_strings(input int n_items);
        int made, len, j;
        made = 0;
        while (made < n_items) begin
            tx_choppy = ($urandom_range(0, 2) != 0);
            if (loaded_codes.size() == 0 || $urandom_range(0, 5) == 0) begin
                load_glyph(IDX_BITS'($urandom), rand_coord(), rand_coord(), rand_coord(),
                           rand_coord(), 1'($urandom));
                made++;
            end else begin
                len = $urandom_range(1, 8);
                for (j = 0; j < len; j++) begin
                    render_char(loaded_codes[$urandom_range(0, loaded_codes.size() - 1)],
                                (j == 0) ? ($urandom_range(0, 7) != 0)
                                         : ($urandom_range(0, 11) == 0));
                end
                made += len;
            end
        end
        drain_results();
    endtask

    initial begin
        int n;
        foreach (loaded[i]) loaded[i] = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: zero glyph height, texture clamp, start on a load
        load_glyph(8'h41, 12'd10, 12'd20, 12'd100, 12'd200, 1'b1);
        load_glyph(8'h00, 12'd0, 12'd0, 12'hFFF, 12'hFFF, 1'b0);
        load_glyph(8'hFF, 12'hFFF, 12'd1, 12'd0, 12'd0, 1'b0);
        load_glyph(8'h80, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0);
        render_char(8'h41, 1'b1);
        render_char(8'h00, 1'b0);
        render_char(8'h80, 1'b0);
        render_char(8'hFF, 1'b0);
        drain_results();

        // widest glyph at full height drives the pen past the top; no atlas width
        program_regs(16'hFFFF, 13'd0, 13'd4096);
        render_char(8'hFF, 1'b1);
        repeat (17) render_char(8'hFF, 1'b0);
        drain_results();

        program_regs(16'h0000, 13'd1, 13'd1);
        run_strings(RANDOM_ITEMS);
        program_regs(16'hFFFF, 13'd4096, 13'd4096);
        run_strings(RANDOM_ITEMS);
        for (n = 0; n < 3; n++) begin
            program_regs(16'($urandom), 13'($urandom_range(1, 4096)),
                         13'($urandom_range(1, 4096)));
            run_strings(RANDOM_ITEMS);
        end
        program_regs(TEXT_H_RESET, ATLAS_RESET, ATLAS_RESET);
        run_strings(RANDOM_ITEMS);

        // no gaps from here on: one unbroken string of back-to-back characters
        quiet <= 1'b1;
        program_regs(16'h0180, 13'd64, 13'd4096);
        load_glyph(8'h2A, 12'd3, 12'd2, 12'd1, 12'd1, 1'b0);
        render_char(8'h2A, 1'b1);
        for (n = 0; n < TAIL_QUADS; n++) begin
            render_char(8'h2A, 1'b0);
        end
        drain_results();

        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== glyph_quad_generator.f =====
+incdir+hw/rtl
hw/rtl/gqg_pkg.sv
hw/rtl/gqg_ram.sv
hw/rtl/glyph_quad_generator.sv
tb/gqg_tb_pkg.sv
tb/tb_glyph_checker.sv
tb/tb_top.sv
